### rtl/core/tcr_pkg.sv
// shared widths, types and constants for the triangle centroid and radius core
package tcr_pkg;

  // coordinate and derived widths
  localparam int COORD_WIDTH  = 24;
  localparam int RADIUS_WIDTH = COORD_WIDTH + 1;
  localparam int SUM_WIDTH    = COORD_WIDTH + 2;
  localparam int MAG_WIDTH    = COORD_WIDTH;
  localparam int SQ_WIDTH     = 2 * MAG_WIDTH;
  localparam int DSQ_WIDTH    = 2 * RADIUS_WIDTH;
  localparam int NUM_LANES    = 3;
  localparam int NUM_AXES     = 3;
  localparam int AXIS_IDX_W   = $clog2(NUM_AXES);

  // stream data widths, padded to whole bytes
  localparam int IN_FIELDS_W  = NUM_LANES * NUM_AXES * COORD_WIDTH;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = NUM_AXES * COORD_WIDTH + 2 * RADIUS_WIDTH;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // floor divide by three: shift the sum to be non-negative, then multiply by
  // the rounded-up reciprocal; the reciprocal error stays below one part in 2^28
  localparam int DIV3_SHIFT  = SUM_WIDTH + 2;
  localparam int DIV3_MULT_W = DIV3_SHIFT - 1;
  localparam int DIV3_PROD_W = SUM_WIDTH + DIV3_MULT_W;
  localparam logic [DIV3_MULT_W-1:0] DIV3_MULT =
    DIV3_MULT_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
  localparam logic [SUM_WIDTH-1:0] SUM_OFFSET =
    SUM_WIDTH'(64'd3 << (COORD_WIDTH - 1));

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [RADIUS_WIDTH-1:0]       radius_t;
  typedef logic [DSQ_WIDTH-1:0]          dsq_t;

  // centroid unit control
  typedef struct packed {
    logic sum_en;
    logic div_en;
  } cent_ctl_t;

endpackage

### rtl/core/tcr_centroid.sv
// centroid unit: per-axis vertex sum, then floor divide by three
module tcr_centroid import tcr_pkg::*; (
  input  logic      clk,
  input  cent_ctl_t ctl,
  input  coord_t    vert   [NUM_LANES][NUM_AXES],
  output coord_t    center [NUM_AXES]
);

  logic [SUM_WIDTH-1:0]   sum_r    [NUM_AXES];
  logic [SUM_WIDTH-1:0]   sum_nxt  [NUM_AXES];
  logic [DIV3_PROD_W-1:0] prod     [NUM_AXES];
  logic [COORD_WIDTH-1:0] quot     [NUM_AXES];
  coord_t                 center_r [NUM_AXES];

  // offset sum, always non-negative and below three times the coordinate span
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sum_nxt[k] = SUM_WIDTH'(vert[0][k]) + SUM_WIDTH'(vert[1][k])
                 + SUM_WIDTH'(vert[2][k]) + SUM_OFFSET;
    end
  end

  // reciprocal multiply, quotient lands in the coordinate range plus half span
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      prod[k] = DIV3_PROD_W'(sum_r[k]) * DIV3_PROD_W'(DIV3_MULT);
      quot[k] = prod[k][DIV3_SHIFT +: COORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if (ctl.sum_en) begin
        sum_r[k] <= sum_nxt[k];
      end
      // removing the half-span offset is a flip of the top bit
      if (ctl.div_en) begin
        center_r[k] <= {~quot[k][COORD_WIDTH-1], quot[k][COORD_WIDTH-2:0]};
      end
    end
  end

  assign center = center_r;

endmodule

### rtl/core/tcr_lane.sv
// distance lane: squared distance from the centroid to one vertex, one axis a cycle
module tcr_lane import tcr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  coord_t vertex [NUM_AXES],
  input  coord_t center [NUM_AXES],
  output dsq_t   dist_sq,
  output logic   done
);

  logic [AXIS_IDX_W-1:0]  step_r;
  logic                   run_r;
  logic                   add_r;
  logic                   done_r;
  logic [SQ_WIDTH-1:0]    prod_r;
  dsq_t                   acc_r;
  logic [COORD_WIDTH:0]   diff;
  logic [MAG_WIDTH-1:0]   mag;

  // difference of one axis and its magnitude
  always_comb begin
    diff = {vertex[step_r][COORD_WIDTH-1], vertex[step_r]}
         - {center[step_r][COORD_WIDTH-1], center[step_r]};
    mag  = diff[COORD_WIDTH] ? MAG_WIDTH'(-diff) : diff[MAG_WIDTH-1:0];
  end

  // control: axis counter, accumulate in the cycle after the square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      add_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      add_r  <= run_r;
      done_r <= add_r && !run_r;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r == AXIS_IDX_W'(NUM_AXES - 1)) begin
          run_r <= 1'b0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  // square and accumulate
  always_ff @(posedge clk) begin
    prod_r <= SQ_WIDTH'(mag) * SQ_WIDTH'(mag);
    if (start) begin
      acc_r <= '0;
    end else if (add_r) begin
      acc_r <= acc_r + DSQ_WIDTH'(prod_r);
    end
  end

  assign dist_sq = acc_r;
  assign done    = done_r;

endmodule

### rtl/core/tcr_isqrt.sv
// bit-serial integer square root, one root bit a cycle
module tcr_isqrt import tcr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dsq_t    radicand,
  output radius_t root,
  output logic    done
);

  localparam int REM_W = RADIUS_WIDTH + 2;
  localparam int CNT_W = $clog2(RADIUS_WIDTH);
  localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(RADIUS_WIDTH - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  dsq_t             rad_r;
  logic [REM_W-1:0] rem_r;
  radius_t          root_r;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[DSQ_WIDTH-1 -: 2]};
    trial  = REM_W'({root_r[RADIUS_WIDTH-2:0], 2'b01});
    fits   = rem_sh >= trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ITER_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[RADIUS_WIDTH-2:0], fits};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

### rtl/core/triangle_centroid_radius_core.sv
// triangle centroid and bounding radius core, top level
//
// One triangle enters per item on the in_ stream: nine signed Q8.16
// coordinates in in_tdata and the end-of-mesh mark in in_tlast. One result
// item leaves on the out_ stream: the centroid (floor of the vertex sum over
// three), the bounding radius (floor of the root of the largest squared
// centroid-to-vertex distance), the running mesh maximum including this
// triangle, and in out_tlast a copy of the end-of-mesh mark.
// Three distance lanes, one per vertex, square one axis per cycle; a merge
// stage keeps the largest sum and a bit-serial root unit finishes the item.
// Each item passes through sum, divide, a lane pass, merge, root iteration
// and the output write before out_tvalid rises. One item is worked at a time
// and in_tready returns the cycle after the write, so no new item is taken
// until the current result is written.
// A finished result sits in the output register and the next item is taken
// while it waits; a stalled receiver holds the block only when the next
// result is ready to be written. The running maximum clears after the item
// marked last. Reset (rst_n low, synchronous) empties the output register,
// idles the block and clears the running maximum.
module triangle_centroid_radius_core import tcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
  // vertex_c_x, vertex_c_y, vertex_c_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // center_x, center_y, center_z, triangle_radius, mesh_max_radius, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_DIST,
    S_MERGE,
    S_ROOT,
    S_WRITE
  } state_t;

  state_t    state_r;
  coord_t    vert_r   [NUM_LANES][NUM_AXES];
  logic      last_r;
  coord_t    center   [NUM_AXES];
  cent_ctl_t cent_ctl;
  dsq_t      lane_dsq [NUM_LANES];
  logic      lane_done [NUM_LANES];
  dsq_t      best_nxt;
  dsq_t      best_r;
  radius_t   root;
  logic      root_done;
  radius_t   run_max_r;
  radius_t   mesh_max;
  logic      out_free;
  logic      load_out;
  logic      out_tvalid_r;
  logic      out_tlast_r;
  coord_t    out_center_r [NUM_AXES];
  radius_t   out_radius_r;
  radius_t   out_max_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign load_out  = (state_r == S_WRITE) && out_free;

  // input capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          vert_r[i][k] <= in_tdata[(i * NUM_AXES + k) * COORD_WIDTH +: COORD_WIDTH];
        end
      end
      last_r <= in_tlast;
    end
  end

  // centroid
  assign cent_ctl.sum_en = (state_r == S_SUM);
  assign cent_ctl.div_en = (state_r == S_DIV);

  tcr_centroid u_centroid (
    .clk    (clk),
    .ctl    (cent_ctl),
    .vert   (vert_r),
    .center (center)
  );

  // one distance lane per vertex
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tcr_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (state_r == S_DIV),
      .vertex  (vert_r[g]),
      .center  (center),
      .dist_sq (lane_dsq[g]),
      .done    (lane_done[g])
    );
  end

  // merge: largest squared distance over the lanes
  always_comb begin
    best_nxt = lane_dsq[0];
    for (int i = 1; i < NUM_LANES; i++) begin
      if (lane_dsq[i] > best_nxt) begin
        best_nxt = lane_dsq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIST && lane_done[0]) begin
      best_r <= best_nxt;
    end
  end

  // root unit
  tcr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_MERGE),
    .radicand (best_r),
    .root     (root),
    .done     (root_done)
  );

  assign mesh_max = (root > run_max_r) ? root : run_max_r;

  // sequencer, running maximum and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_max_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          state_r <= S_DIST;
        end
        S_DIST: begin
          if (lane_done[0]) begin
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            state_r   <= S_IDLE;
            run_max_r <= last_r ? '0 : mesh_max;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_center_r <= center;
      out_radius_r <= root;
      out_max_r    <= mesh_max;
      out_tlast_r  <= last_r;
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      out_tdata[k * COORD_WIDTH +: COORD_WIDTH] = out_center_r[k];
    end
    out_tdata[NUM_AXES * COORD_WIDTH +: RADIUS_WIDTH] = out_radius_r;
    out_tdata[NUM_AXES * COORD_WIDTH + RADIUS_WIDTH +: RADIUS_WIDTH] = out_max_r;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;

  // the running maximum is empty after the last item of a mesh is written
  a_mesh_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && last_r |=> run_max_r == '0)
    else $error("running maximum not cleared after mesh end");

  // a delivered mesh maximum never falls below its own triangle's radius
  a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_max_r >= out_radius_r)
    else $error("mesh maximum below triangle radius");

  // the three lanes run in lockstep
  a_lanes_lock: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
    else $error("distance lanes out of step");

  // a root finishes only while the sequencer waits for it
  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == S_ROOT)
    else $error("root result outside its wait state");

endmodule
